>>> sv/waypoint_speed_profiler_unit_assert.svh
// ----------------------------------------------------------------------------
// Waypoint speed profiler assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_SPEED_PROFILER_UNIT_ASSERT_SVH
`define WAYPOINT_SPEED_PROFILER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared codes, constants and defaults of the waypoint speed profiler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsp_pkg;

    typedef logic [2:0] phase_t;
    typedef logic [1:0] cause_t;

    // phase codes
    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_ACCEL  = 3'd1;
    localparam phase_t PH_CRUISE = 3'd2;
    localparam phase_t PH_DECEL  = 3'd3;
    localparam phase_t PH_SLOW   = 3'd4;

    // end causes
    localparam cause_t CAUSE_NONE    = 2'd0;
    localparam cause_t CAUSE_REACHED = 2'd1;
    localparam cause_t CAUSE_TIMEOUT = 2'd2;
    localparam cause_t CAUSE_OVERRUN = 2'd3;

    // input commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_STEP_UP     = 3'd0;
    localparam logic [2:0] REG_STEP_DOWN   = 3'd1;
    localparam logic [2:0] REG_CRUISE_SPD  = 3'd2;
    localparam logic [2:0] REG_ACCEL_TICKS = 3'd3;
    localparam logic [2:0] REG_DECEL_TICKS = 3'd4;
    localparam logic [2:0] REG_CRUISE_EXIT = 3'd5;
    localparam logic [2:0] REG_HEADING_TOL = 3'd6;
    localparam logic [2:0] REG_TURN_GAIN   = 3'd7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register reset values
    localparam logic [9:0]  RST_STEP_UP     = 10'd10;
    localparam logic [9:0]  RST_STEP_DOWN   = 10'd10;
    localparam logic [10:0] RST_CRUISE_SPD  = 11'd200;
    localparam logic [15:0] RST_ACCEL_TICKS = 16'd100;
    localparam logic [15:0] RST_DECEL_TICKS = 16'd100;
    localparam logic [15:0] RST_CRUISE_EXIT = 16'd300;
    localparam logic [13:0] RST_HEADING_TOL = 14'd200;
    localparam logic [15:0] RST_TURN_GAIN   = 16'd4096;

    // Q12 angle limits
    localparam logic [15:0] PI_Q12       = 16'd12868;
    localparam logic [16:0] TWO_PI_Q12   = 17'd25736;
    localparam logic [15:0] FLIP_LIM_Q12 = 16'd21446;  // 300 deg
    localparam logic [15:0] OVRN_LIM_Q12 = 16'd7148;   // 100 deg

    // parameter defaults
    localparam int DEF_ACCEL_UPDATE_PERIOD = 4;
    localparam int DEF_DECEL_UPDATE_PERIOD = 4;
    localparam int DEF_SLOW_TIMEOUT_TICKS  = 1000;
    localparam int DEF_ACCEL_EXIT_DIST     = 150;
    localparam int DEF_SLOW_EXIT_DIST      = 10;

endpackage

>>> sv/waypoint_speed_profiler_unit.sv
// ----------------------------------------------------------------------------
// waypoint_speed_profiler_unit
// Trapezoidal linear speed profile with proportional heading correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): cmd, dist_mm, heading_err. A start
//   (cmd=1) arms a move; each tick (cmd=0) advances the profile one step.
//   Output channel (out_valid/out_ready): one result per input transfer,
//   lin_vel, ang_vel, phase, move_done, end_cause, in input order.
//   Order: an input transfer lands in the input register; the result
//   register loads from it once the receiver can take a result, and
//   out_valid rises with that load. Throughput: one item per cycle while
//   the receiver takes results, set by the combinational path from input
//   register (heading multiply, phase chain) to result register.
//   Receiver stall: the result register holds; the input register still
//   takes one more item, then in_ready drops until the result is taken.
//   Reset (rst_n low, async): phase idle, speeds and counters zero, both
//   channels empty, registers at their defaults.
//   APB port: 8 registers at byte address 4*i, writes at the access cycle,
//   pready tied high; write only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "waypoint_speed_profiler_unit_assert.svh"

module waypoint_speed_profiler_unit #(
    parameter int ACCEL_UPDATE_PERIOD = wsp_pkg::DEF_ACCEL_UPDATE_PERIOD,
    parameter int DECEL_UPDATE_PERIOD = wsp_pkg::DEF_DECEL_UPDATE_PERIOD,
    parameter int SLOW_TIMEOUT_TICKS  = wsp_pkg::DEF_SLOW_TIMEOUT_TICKS,
    parameter int ACCEL_EXIT_DIST     = wsp_pkg::DEF_ACCEL_EXIT_DIST,
    parameter int SLOW_EXIT_DIST      = wsp_pkg::DEF_SLOW_EXIT_DIST
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [wsp_pkg::DATA_W-1:0]    pwdata,
    output logic [wsp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [15:0]                   dist_mm,
    input  logic signed [15:0]            heading_err,
    // output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            lin_vel,
    output logic signed [15:0]            ang_vel,
    output logic [2:0]                    phase,
    output logic                          move_done,
    output logic [1:0]                    end_cause
);

    localparam int MaxPeriod = (ACCEL_UPDATE_PERIOD > DECEL_UPDATE_PERIOD) ?
                               ACCEL_UPDATE_PERIOD : DECEL_UPDATE_PERIOD;
    localparam int CntW = (MaxPeriod > 1) ? $clog2(MaxPeriod) : 1;

    localparam logic [CntW-1:0] AccLast   = CntW'(ACCEL_UPDATE_PERIOD - 1);
    localparam logic [CntW-1:0] DecLast   = CntW'(DECEL_UPDATE_PERIOD - 1);
    localparam logic [15:0]     SlowLimit = 16'(SLOW_TIMEOUT_TICKS);
    localparam logic [15:0]     AccExit   = 16'(ACCEL_EXIT_DIST);
    localparam logic [15:0]     SlowExit  = 16'(SLOW_EXIT_DIST);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [9:0]  step_up_reg;
    logic [9:0]  step_down_reg;
    logic [10:0] cruise_speed_reg;
    logic [15:0] accel_ticks_reg;
    logic [15:0] decel_ticks_reg;
    logic [15:0] cruise_exit_reg;
    logic [13:0] heading_tol_reg;
    logic [15:0] turn_gain_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_up_reg      <= wsp_pkg::RST_STEP_UP;
            step_down_reg    <= wsp_pkg::RST_STEP_DOWN;
            cruise_speed_reg <= wsp_pkg::RST_CRUISE_SPD;
            accel_ticks_reg  <= wsp_pkg::RST_ACCEL_TICKS;
            decel_ticks_reg  <= wsp_pkg::RST_DECEL_TICKS;
            cruise_exit_reg  <= wsp_pkg::RST_CRUISE_EXIT;
            heading_tol_reg  <= wsp_pkg::RST_HEADING_TOL;
            turn_gain_reg    <= wsp_pkg::RST_TURN_GAIN;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                wsp_pkg::REG_STEP_UP:     step_up_reg      <= pwdata[9:0];
                wsp_pkg::REG_STEP_DOWN:   step_down_reg    <= pwdata[9:0];
                wsp_pkg::REG_CRUISE_SPD:  cruise_speed_reg <= pwdata[10:0];
                wsp_pkg::REG_ACCEL_TICKS: accel_ticks_reg  <= pwdata[15:0];
                wsp_pkg::REG_DECEL_TICKS: decel_ticks_reg  <= pwdata[15:0];
                wsp_pkg::REG_CRUISE_EXIT: cruise_exit_reg  <= pwdata[15:0];
                wsp_pkg::REG_HEADING_TOL: heading_tol_reg  <= pwdata[13:0];
                wsp_pkg::REG_TURN_GAIN:   turn_gain_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            wsp_pkg::REG_STEP_UP:     prdata = {22'd0, step_up_reg};
            wsp_pkg::REG_STEP_DOWN:   prdata = {22'd0, step_down_reg};
            wsp_pkg::REG_CRUISE_SPD:  prdata = {21'd0, cruise_speed_reg};
            wsp_pkg::REG_ACCEL_TICKS: prdata = {16'd0, accel_ticks_reg};
            wsp_pkg::REG_DECEL_TICKS: prdata = {16'd0, decel_ticks_reg};
            wsp_pkg::REG_CRUISE_EXIT: prdata = {16'd0, cruise_exit_reg};
            wsp_pkg::REG_HEADING_TOL: prdata = {18'd0, heading_tol_reg};
            wsp_pkg::REG_TURN_GAIN:   prdata = {16'd0, turn_gain_reg};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: input register -> result register
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic [15:0]        s1_dist_reg;
    logic signed [15:0] s1_err_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               fire;

    assign advance  = ~out_valid_reg | out_ready;
    assign in_ready = ~s1_valid_reg | advance;
    assign fire     = s1_valid_reg & advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg  <= cmd;
            s1_dist_reg <= dist_mm;
            s1_err_reg  <= heading_err;
        end
    end

    // ------------------------------------------------------------------
    // heading correction
    // ------------------------------------------------------------------
    logic [15:0]        mag;
    logic signed [16:0] wrapped;
    logic               corr;
    logic [29:0]        prod;
    logic [30:0]        prod_rnd;
    logic [18:0]        ang_mag;
    logic [15:0]        ang_sat;
    logic               ang_neg;
    logic signed [15:0] ang_corr;

    // magnitude of -32768 is 32768, still fits 16 unsigned bits
    assign mag     = s1_err_reg[15] ? (~s1_err_reg + 16'd1) : s1_err_reg;
    assign wrapped = (mag > wsp_pkg::PI_Q12) ?
                     $signed(wsp_pkg::TWO_PI_Q12 - {1'b0, mag}) : $signed({1'b0, mag});
    assign corr    = wrapped > $signed({3'b000, heading_tol_reg});

    // only used when wrapped > tol >= 0, so wrapped[13:0] holds it
    assign prod     = turn_gain_reg * wrapped[13:0];
    assign prod_rnd = {1'b0, prod} + 31'd2048;
    assign ang_mag  = prod_rnd[30:12];
    assign ang_sat  = (ang_mag > 19'd32767) ? 16'd32767 : ang_mag[15:0];
    assign ang_neg  = ~s1_err_reg[15] ^ (mag > wsp_pkg::FLIP_LIM_Q12);
    assign ang_corr = ang_neg ? $signed(~ang_sat + 16'd1) : $signed(ang_sat);

    // ------------------------------------------------------------------
    // profile state and phase chain
    // ------------------------------------------------------------------
    wsp_pkg::phase_t    move_phase_reg, move_phase_next;
    logic [15:0]        phase_ticks_reg, phase_ticks_next;
    logic signed [15:0] lin_speed_reg, lin_speed_next;
    logic signed [15:0] ang_speed_reg, ang_speed_next;
    logic [CntW-1:0]    upd_cnt_reg, upd_cnt_next;   // phase_ticks mod period
    logic               done_next;
    wsp_pkg::cause_t    cause_next;
    logic               emitted;
    logic               fresh;
    logic [16:0]        lin_up;
    logic [16:0]        lin_dn;
    logic [15:0]        slow_ticks;

    function automatic logic signed [15:0] sat16(input logic [16:0] v);
        if (v[16] != v[15])
            sat16 = v[16] ? 16'sh8000 : 16'sh7fff;
        else
            sat16 = $signed(v[15:0]);
    endfunction

    always_comb
    begin
        move_phase_next  = move_phase_reg;
        phase_ticks_next = phase_ticks_reg;
        lin_speed_next   = lin_speed_reg;
        ang_speed_next   = ang_speed_reg;
        upd_cnt_next     = upd_cnt_reg;
        done_next        = 1'b0;
        cause_next       = wsp_pkg::CAUSE_NONE;
        emitted          = 1'b0;
        fresh            = 1'b0;
        lin_up           = '0;
        lin_dn           = '0;
        slow_ticks       = '0;

        if (s1_cmd_reg == wsp_pkg::CMD_START)
        begin
            move_phase_next  = wsp_pkg::PH_ACCEL;
            phase_ticks_next = '0;
            upd_cnt_next     = '0;
        end
        else if (move_phase_reg < wsp_pkg::PH_ACCEL || move_phase_reg > wsp_pkg::PH_SLOW)
        begin
            move_phase_next = wsp_pkg::PH_IDLE;
        end
        else
        begin
            if (corr)
                ang_speed_next = ang_corr;

            if (move_phase_next == wsp_pkg::PH_ACCEL)
            begin
                if (phase_ticks_next < accel_ticks_reg && s1_dist_reg > AccExit)
                begin
                    lin_up = {lin_speed_next[15], lin_speed_next} + {7'd0, step_up_reg};
                    if (upd_cnt_next == '0)
                        lin_speed_next = sat16(lin_up);
                    upd_cnt_next     = (upd_cnt_next == AccLast) ? '0 : upd_cnt_next + 1'b1;
                    phase_ticks_next = phase_ticks_next + 16'd1;
                    emitted          = 1'b1;
                end
                else
                begin
                    move_phase_next  = wsp_pkg::PH_CRUISE;
                    lin_speed_next   = $signed({5'd0, cruise_speed_reg});
                    ang_speed_next   = '0;
                    phase_ticks_next = '0;
                    upd_cnt_next     = '0;
                    fresh            = 1'b1;
                end
            end

            if (!emitted && move_phase_next == wsp_pkg::PH_CRUISE)
            begin
                if (s1_dist_reg > cruise_exit_reg)
                    emitted = 1'b1;
                else
                begin
                    move_phase_next  = wsp_pkg::PH_DECEL;
                    phase_ticks_next = '0;
                    upd_cnt_next     = '0;
                    fresh            = 1'b1;
                end
            end

            if (!emitted && move_phase_next == wsp_pkg::PH_DECEL)
            begin
                if (phase_ticks_next < decel_ticks_reg)
                begin
                    lin_dn = {lin_speed_next[15], lin_speed_next} - {7'd0, step_down_reg};
                    if (upd_cnt_next == '0)
                        lin_speed_next = sat16(lin_dn);
                    upd_cnt_next     = (upd_cnt_next == DecLast) ? '0 : upd_cnt_next + 1'b1;
                    phase_ticks_next = phase_ticks_next + 16'd1;
                    emitted          = 1'b1;
                end
                else
                begin
                    move_phase_next  = wsp_pkg::PH_SLOW;
                    phase_ticks_next = '0;
                    upd_cnt_next     = '0;
                    fresh            = 1'b1;
                end
            end

            if (!emitted && move_phase_next == wsp_pkg::PH_SLOW)
            begin
                // timeout and overrun only count on ticks after the first slow one
                if (!fresh)
                begin
                    slow_ticks       = phase_ticks_next + 16'd1;
                    phase_ticks_next = slow_ticks;
                    if (slow_ticks >= SlowLimit)
                        cause_next = wsp_pkg::CAUSE_TIMEOUT;
                    else if (mag > wsp_pkg::OVRN_LIM_Q12)
                        cause_next = wsp_pkg::CAUSE_OVERRUN;
                end
                if (cause_next == wsp_pkg::CAUSE_NONE && s1_dist_reg <= SlowExit)
                    cause_next = wsp_pkg::CAUSE_REACHED;
                if (cause_next != wsp_pkg::CAUSE_NONE)
                begin
                    move_phase_next  = wsp_pkg::PH_IDLE;
                    phase_ticks_next = '0;
                    upd_cnt_next     = '0;
                    lin_speed_next   = '0;
                    ang_speed_next   = '0;
                    done_next        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_phase_reg  <= wsp_pkg::PH_IDLE;
            phase_ticks_reg <= '0;
            lin_speed_reg   <= '0;
            ang_speed_reg   <= '0;
            upd_cnt_reg     <= '0;
        end
        else if (fire)
        begin
            move_phase_reg  <= move_phase_next;
            phase_ticks_reg <= phase_ticks_next;
            lin_speed_reg   <= lin_speed_next;
            ang_speed_reg   <= ang_speed_next;
            upd_cnt_reg     <= upd_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic signed [15:0] lin_vel_reg;
    logic signed [15:0] ang_vel_reg;
    wsp_pkg::phase_t    phase_reg;
    logic               move_done_reg;
    wsp_pkg::cause_t    end_cause_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            lin_vel_reg   <= lin_speed_next;
            ang_vel_reg   <= ang_speed_next;
            phase_reg     <= move_phase_next;
            move_done_reg <= done_next;
            end_cause_reg <= cause_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign lin_vel   = lin_vel_reg;
    assign ang_vel   = ang_vel_reg;
    assign phase     = phase_reg;
    assign move_done = move_done_reg;
    assign end_cause = end_cause_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `WSP_ASSERT_NOW(a_done_stops, clk, rst_n,
        out_valid_reg && move_done_reg,
        phase_reg == wsp_pkg::PH_IDLE && lin_vel_reg == 16'sd0 && ang_vel_reg == 16'sd0,
        "final stop result is not an idle zero-speed command")
    `WSP_ASSERT_NOW(a_cause_match, clk, rst_n,
        out_valid_reg,
        move_done_reg == (end_cause_reg != wsp_pkg::CAUSE_NONE),
        "end cause disagrees with move_done")
    `WSP_ASSERT_NOW(a_idle_zero, clk, rst_n,
        move_phase_reg == wsp_pkg::PH_IDLE,
        lin_speed_reg == 16'sd0 && ang_speed_reg == 16'sd0,
        "held speeds not zero while idle")
    `WSP_ASSERT_NOW(a_cruise_cnt, clk, rst_n,
        move_phase_reg == wsp_pkg::PH_CRUISE,
        phase_ticks_reg == 16'd0 && upd_cnt_reg == '0,
        "tick counters running during cruise")
    `WSP_ASSERT_NEXT(a_result_loads, clk, rst_n,
        fire,
        out_valid_reg && phase_reg == $past(move_phase_next),
        "result register missed a finished item")

endmodule

>>> dv/waypoint_speed_profiler_unit_checker.sv
// ----------------------------------------------------------------------------
// waypoint_speed_profiler_unit_checker
// Watches the register port and both channels of the speed profiler. It keeps
// its own copy of the registers and of the move state, works out the speed
// command that each input transfer must produce, and compares every output
// transfer with the oldest command still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waypoint_speed_profiler_unit_checker
    import wsp_pkg::*;
#(
    parameter int ACCEL_PERIOD = DEF_ACCEL_UPDATE_PERIOD,
    parameter int DECEL_PERIOD = DEF_DECEL_UPDATE_PERIOD,
    parameter int SLOW_TIMEOUT = DEF_SLOW_TIMEOUT_TICKS,
    parameter int ACCEL_EXIT   = DEF_ACCEL_EXIT_DIST,
    parameter int SLOW_EXIT    = DEF_SLOW_EXIT_DIST
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic                 pready,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 cmd,
    input  logic [15:0]          dist_mm,
    input  logic signed [15:0]   heading_err,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic signed [15:0]   lin_vel,
    input  logic signed [15:0]   ang_vel,
    input  logic [2:0]           phase,
    input  logic                 move_done,
    input  logic [1:0]           end_cause,
    output int                   errors,
    output int                   pending,
    output int                   checked,
    output int                   n_reached,
    output int                   n_timeout,
    output int                   n_overrun
);

    typedef struct packed {
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        phase_t             ph;
        logic               done;
        cause_t             why;
    } speed_cmd_t;

    speed_cmd_t speed_cmds_due[$];
    speed_cmd_t want;
    speed_cmd_t got;

    // register copy
    logic [9:0]  r_step_up;
    logic [9:0]  r_step_down;
    logic [10:0] r_cruise;
    logic [15:0] r_acc_ticks;
    logic [15:0] r_dec_ticks;
    logic [15:0] r_cruise_exit;
    logic [13:0] r_tol;
    logic [15:0] r_gain;

    // move state
    phase_t      mv_phase;
    logic [15:0] mv_ticks;
    int          lin_q;
    int          ang_q;

    function automatic int sat16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return int'(v);
    endfunction

    task automatic next_speed_cmd(input logic c, input logic [15:0] d_mm,
                                  input logic signed [15:0] herr,
                                  output speed_cmd_t r);
        int     e;
        int     mag;
        int     w;
        longint m;
        logic   fresh;
        logic   busy;
        logic   done;
        cause_t why;
        e     = herr;
        mag   = (e < 0) ? -e : e;
        fresh = 1'b0;
        busy  = 1'b1;
        done  = 1'b0;
        why   = CAUSE_NONE;
        if (c == CMD_START)
        begin
            mv_phase = PH_ACCEL;
            mv_ticks = '0;
        end
        else if (mv_phase != PH_IDLE)
        begin
            // wrap into [0, pi]; past 300 degrees the correction turns the other way
            w = (mag > int'(PI_Q12)) ? int'(TWO_PI_Q12) - mag : mag;
            if (w > int'(r_tol))
            begin
                m = (longint'(r_gain) * w + 2048) >>> 12;
                if (m > 32767)
                    m = 32767;
                ang_q = int'(m);
                if (e >= 0)
                    ang_q = -ang_q;
                if (mag > int'(FLIP_LIM_Q12))
                    ang_q = -ang_q;
            end
            // a phase whose exit already holds falls through to the next one
            while (busy)
            begin
                case (mv_phase)
                    PH_ACCEL:
                    begin
                        if (mv_ticks < r_acc_ticks && d_mm > ACCEL_EXIT)
                        begin
                            if (mv_ticks % ACCEL_PERIOD == 0)
                                lin_q = sat16(longint'(lin_q) + longint'(r_step_up));
                            mv_ticks = mv_ticks + 16'd1;
                            busy = 1'b0;
                        end
                        else
                        begin
                            mv_phase = PH_CRUISE;
                            lin_q    = int'(r_cruise);
                            ang_q    = 0;
                            mv_ticks = '0;
                            fresh    = 1'b1;
                        end
                    end
                    PH_CRUISE:
                    begin
                        if (d_mm > r_cruise_exit)
                            busy = 1'b0;
                        else
                        begin
                            mv_phase = PH_DECEL;
                            mv_ticks = '0;
                            fresh    = 1'b1;
                        end
                    end
                    PH_DECEL:
                    begin
                        if (mv_ticks < r_dec_ticks)
                        begin
                            if (mv_ticks % DECEL_PERIOD == 0)
                                lin_q = sat16(longint'(lin_q) - longint'(r_step_down));
                            mv_ticks = mv_ticks + 16'd1;
                            busy = 1'b0;
                        end
                        else
                        begin
                            mv_phase = PH_SLOW;
                            mv_ticks = '0;
                            fresh    = 1'b1;
                        end
                    end
                    default:
                    begin
                        // timeout and overrun only after the first slow-approach tick
                        if (!fresh)
                        begin
                            mv_ticks = mv_ticks + 16'd1;
                            if (mv_ticks >= SLOW_TIMEOUT)
                                why = CAUSE_TIMEOUT;
                            else if (mag > int'(OVRN_LIM_Q12))
                                why = CAUSE_OVERRUN;
                        end
                        if (why == CAUSE_NONE && d_mm <= SLOW_EXIT)
                            why = CAUSE_REACHED;
                        if (why != CAUSE_NONE)
                        begin
                            mv_phase = PH_IDLE;
                            mv_ticks = '0;
                            lin_q    = 0;
                            ang_q    = 0;
                            done     = 1'b1;
                            case (why)
                                CAUSE_REACHED: n_reached++;
                                CAUSE_TIMEOUT: n_timeout++;
                                default:       n_overrun++;
                            endcase
                        end
                        busy = 1'b0;
                    end
                endcase
            end
        end
        r.lin  = lin_q[15:0];
        r.ang  = ang_q[15:0];
        r.ph   = mv_phase;
        r.done = done;
        r.why  = why;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_step_up     = RST_STEP_UP;
            r_step_down   = RST_STEP_DOWN;
            r_cruise      = RST_CRUISE_SPD;
            r_acc_ticks   = RST_ACCEL_TICKS;
            r_dec_ticks   = RST_DECEL_TICKS;
            r_cruise_exit = RST_CRUISE_EXIT;
            r_tol         = RST_HEADING_TOL;
            r_gain        = RST_TURN_GAIN;
            mv_phase      = PH_IDLE;
            mv_ticks      = '0;
            lin_q         = 0;
            ang_q         = 0;
            speed_cmds_due.delete();
            errors        = 0;
            pending       = 0;
            checked       = 0;
            n_reached     = 0;
            n_timeout     = 0;
            n_overrun     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_STEP_UP:     r_step_up     = pwdata[9:0];
                    REG_STEP_DOWN:   r_step_down   = pwdata[9:0];
                    REG_CRUISE_SPD:  r_cruise      = pwdata[10:0];
                    REG_ACCEL_TICKS: r_acc_ticks   = pwdata[15:0];
                    REG_DECEL_TICKS: r_dec_ticks   = pwdata[15:0];
                    REG_CRUISE_EXIT: r_cruise_exit = pwdata[15:0];
                    REG_HEADING_TOL: r_tol         = pwdata[13:0];
                    REG_TURN_GAIN:   r_gain        = pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                next_speed_cmd(cmd, dist_mm, heading_err, want);
                speed_cmds_due.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got.lin  = lin_vel;
                got.ang  = ang_vel;
                got.ph   = phase;
                got.done = move_done;
                got.why  = end_cause;
                if (speed_cmds_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with none due: lin=%0d ang=%0d phase=%0d done=%0b cause=%0d",
                             $time, got.lin, got.ang, got.ph, got.done, got.why);
                end
                else
                begin
                    want = speed_cmds_due.pop_front();
                    checked++;
                    if (got.lin !== want.lin || got.ang !== want.ang || got.ph !== want.ph ||
                        got.done !== want.done || got.why !== want.why)
                    begin
                        errors++;
                        $display("%0t: mismatch on result %0d: expected lin=%0d ang=%0d phase=%0d done=%0b cause=%0d",
                                 $time, checked, want.lin, want.ang, want.ph, want.done, want.why);
                        $display("%0t:                       actual   lin=%0d ang=%0d phase=%0d done=%0b cause=%0d",
                                 $time, got.lin, got.ang, got.ph, got.done, got.why);
                    end
                end
            end
            pending = speed_cmds_due.size();
        end
    end

endmodule

>>> dv/waypoint_speed_profiler_unit_tb.sv
// ----------------------------------------------------------------------------
// waypoint_speed_profiler_unit_tb
// Drives the speed profiler with directed moves and then with random moves
// under a series of register settings, with random idling on both channels.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waypoint_speed_profiler_unit_tb;
    import wsp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // register settings of a segment
    localparam int SET_MIN     = 0;
    localparam int SET_MAX     = 1;
    localparam int SET_SAT     = 2;
    localparam int SET_RAND    = 3;
    localparam int SET_SLOWOUT = 4;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 cmd = CMD_TICK;
    logic [15:0]          dist_mm = '0;
    logic signed [15:0]   heading_err = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [15:0]   lin_vel;
    logic signed [15:0]   ang_vel;
    logic [2:0]           phase;
    logic                 move_done;
    logic [1:0]           end_cause;

    int errors;
    int pending;
    int checked;
    int n_reached;
    int n_timeout;
    int n_overrun;

    int cycles = 0;
    int sent = 0;
    int settings = 1;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;

    always #5 clk = ~clk;

    waypoint_speed_profiler_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .dist_mm(dist_mm),
        .heading_err(heading_err),
        .out_valid(out_valid), .out_ready(out_ready), .lin_vel(lin_vel),
        .ang_vel(ang_vel), .phase(phase), .move_done(move_done), .end_cause(end_cause)
    );

    waypoint_speed_profiler_unit_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .dist_mm(dist_mm),
        .heading_err(heading_err),
        .out_valid(out_valid), .out_ready(out_ready), .lin_vel(lin_vel),
        .ang_vel(ang_vel), .phase(phase), .move_done(move_done), .end_cause(end_cause),
        .errors(errors), .pending(pending), .checked(checked),
        .n_reached(n_reached), .n_timeout(n_timeout), .n_overrun(n_overrun)
    );

    always @(negedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("FAIL waypoint_speed_profiler_unit");
            $finish;
        end
    end

    // receiver stalls in bursts of random length, started with a chance of stall_pct percent
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready = 1'b0;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 15) - 1;
            out_ready = 1'b0;
        end
        else
            out_ready = 1'b1;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_item(input logic c, input logic [15:0] d, input logic [15:0] h);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        cmd         = c;
        dist_mm     = d;
        heading_err = h;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic wait_all_results();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [15:0] pick_heading(int spread);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, 2 * spread) - spread);
        if (r < 92)
            return 16'($urandom);
        case ($urandom_range(0, 10))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return PI_Q12;
            3:       return -(PI_Q12 + 16'd1);
            4:       return FLIP_LIM_Q12;
            5:       return FLIP_LIM_Q12 + 16'd1;
            6:       return -(FLIP_LIM_Q12 + 16'd1);
            7:       return OVRN_LIM_Q12;
            8:       return OVRN_LIM_Q12 + 16'd1;
            9:       return -(OVRN_LIM_Q12 + 16'd1);
            default: return 16'h0000;
        endcase
    endfunction

    function automatic int pick_small(int small_max, int full_max);
        return ($urandom_range(0, 99) < 75) ? $urandom_range(0, small_max)
                                             : $urandom_range(0, full_max);
    endfunction

    // only called with nothing due
    task automatic apply_setting(int kind);
        logic [31:0] v [8];
        case (kind)
            SET_MIN:
                foreach (v[i]) v[i] = '0;
            SET_MAX:
                v = '{1000, 1000, 2000, 65535, 65535, 65535, 12868, 65535};
            SET_SAT:
                v = '{1000, 1000, 0, 65535, 65535, 65535, 0, 65535};
            default:
            begin
                v[REG_STEP_UP]     = pick_small(60, 1000);
                v[REG_STEP_DOWN]   = pick_small(60, 1000);
                v[REG_CRUISE_SPD]  = $urandom_range(0, 2000);
                v[REG_ACCEL_TICKS] = pick_small(24, 65535);
                v[REG_DECEL_TICKS] = pick_small(24, 65535);
                v[REG_CRUISE_EXIT] = pick_small(1500, 65535);
                v[REG_HEADING_TOL] = pick_small(800, 12868);
                v[REG_TURN_GAIN]   = $urandom_range(0, 65535);
                if (kind == SET_SLOWOUT)
                begin
                    v[REG_ACCEL_TICKS] = 0;
                    v[REG_DECEL_TICKS] = 0;
                    v[REG_CRUISE_EXIT] = 65535;
                end
            end
        endcase
        foreach (v[i])
            write_reg(3'(i), v[i]);
        settings++;
    endtask

    // start, a distance ramp toward the target with occasional restarts and random commands, then a tail near it
    task automatic run_move(int n, int tail, int spread, longint d0);
        int k;
        push_item(CMD_START, 16'($urandom), 16'($urandom));
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 4)
                push_item(CMD_START, 16'($urandom), 16'($urandom));
            else if ($urandom_range(0, 99) < 6)
                push_item(1'($urandom), 16'($urandom), 16'($urandom));
            else
                push_item(CMD_TICK, 16'(d0 * (n - 1 - k) / n + $urandom_range(0, 8)),
                          pick_heading(spread));
        end
        for (k = 0; k < tail; k++)
            push_item(CMD_TICK, 16'($urandom_range(0, 20)), pick_heading(spread));
    endtask

    task automatic run_segment(int kind, int budget, bit calm);
        int     first;
        int     spread;
        longint d0;
        apply_setting(kind);
        gap_pct   = calm ? 0 : $urandom_range(0, 2) * 20;
        stall_pct = calm ? 0 : $urandom_range(0, 2) * 20;
        first     = sent;
        spread    = $urandom_range(100, 3000);
        while (sent - first < budget)
        begin
            if (kind == SET_SAT)
                run_move(140, 140, spread, 65535);
            else
            begin
                d0 = ($urandom_range(0, 99) < 75) ? $urandom_range(200, 4000)
                                                   : $urandom_range(0, 65535);
                run_move($urandom_range(3, 40), $urandom_range(0, 25), spread, d0);
            end
        end
        // hold the sender until every result of the segment is back
        wait_all_results();
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part with reset register values
        gap_pct   = 20;
        stall_pct = 20;
        push_item(CMD_TICK, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'hFFFF, 16'h8000);
        push_item(CMD_START, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'hFFFF, 16'h7FFF);
        push_item(CMD_TICK, 16'hFFFF, 16'h8000);
        push_item(CMD_TICK, 16'd1000, 16'd100);
        push_item(CMD_TICK, 16'd1000, PI_Q12);
        push_item(CMD_TICK, 16'd1000, -(PI_Q12 + 16'd1));
        push_item(CMD_TICK, 16'd1000, FLIP_LIM_Q12 + 16'd1);
        push_item(CMD_TICK, 16'd1000, 16'(RST_HEADING_TOL));
        push_item(CMD_TICK, 16'd150, 16'd0);       // accelerate and cruise exit at once
        push_item(CMD_START, 16'd0, 16'd0);        // restart in the middle of decelerate
        push_item(CMD_TICK, 16'd200, -16'sd201);
        wait_all_results();

        // empty accelerate and decelerate phases: ticks drop straight to slow approach
        write_reg(REG_ACCEL_TICKS, 32'd0);
        write_reg(REG_DECEL_TICKS, 32'd0);
        push_item(CMD_START, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd10, 16'd0);        // arrives on the first slow tick
        push_item(CMD_TICK, 16'd10, 16'd0);
        push_item(CMD_START, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd11, OVRN_LIM_Q12 + 16'd1);
        push_item(CMD_TICK, 16'd11, -OVRN_LIM_Q12);
        push_item(CMD_TICK, 16'd11, -(OVRN_LIM_Q12 + 16'd1));
        push_item(CMD_START, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd11, 16'd0);
        push_item(CMD_TICK, 16'd10, 16'd0);
        push_item(CMD_START, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'hFFFF, 16'h7FFF);
        wait_all_results();

        run_segment(SET_MIN, 30, 1'b0);
        run_segment(SET_MAX, 30, 1'b0);
        run_segment(SET_SAT, 1, 1'b0);
        repeat (3)
            run_segment(SET_RAND, 40, 1'b0);

        // a long slow approach that neither arrives nor overruns
        apply_setting(SET_SLOWOUT);
        gap_pct   = 10;
        stall_pct = 10;
        push_item(CMD_START, 16'd0, 16'd0);
        repeat (30)
            push_item(CMD_TICK, 16'($urandom_range(11, 65535)),
                      16'($urandom_range(0, 14296) - 7148));
        wait_all_results();

        run_segment(SET_RAND, 40, 1'b1);

        repeat (8) @(negedge clk);
        $display("covered %0d input transfers, %0d checked results, %0d register settings",
                 sent, checked, settings);
        $display("moves ended: %0d reached, %0d timed out, %0d heading overrun",
                 n_reached, n_timeout, n_overrun);
        if (errors == 0 && pending == 0)
            $display("PASS waypoint_speed_profiler_unit");
        else
            $display("FAIL waypoint_speed_profiler_unit");
        $finish;
    end

endmodule
